/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/ttok_pkg.sv */
// ----------------------------------------------------------------------------
// ttok_pkg
// Types, codes and character classes shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package ttok_pkg;

  // Lexer modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_SLASH   = 4'd2;
  localparam logic [3:0] M_NUMBER  = 4'd3;
  localparam logic [3:0] M_STRING  = 4'd4;
  localparam logic [3:0] M_ESCAPE  = 4'd5;
  localparam logic [3:0] M_NAME    = 4'd6;
  localparam logic [3:0] M_NODE    = 4'd7;
  localparam logic [3:0] M_INVALID = 4'd8;

  // Token kinds
  localparam logic [3:0] K_EOF         = 4'd0;
  localparam logic [3:0] K_NUMBER      = 4'd1;
  localparam logic [3:0] K_STRING      = 4'd2;
  localparam logic [3:0] K_NAME        = 4'd3;
  localparam logic [3:0] K_EQUALS      = 4'd4;
  localparam logic [3:0] K_COLON       = 4'd5;
  localparam logic [3:0] K_COMMA       = 4'd6;
  localparam logic [3:0] K_BANG        = 4'd7;
  localparam logic [3:0] K_NODE_BEGIN  = 4'd8;
  localparam logic [3:0] K_NODE_END    = 4'd9;
  localparam logic [3:0] K_VEC_BEGIN   = 4'd10;
  localparam logic [3:0] K_VEC_END     = 4'd11;
  localparam logic [3:0] K_INVALID     = 4'd12;
  localparam logic [3:0] K_SLASH_ERROR = 4'd13;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  // Queue depth between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // One result, without its offset
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       first;
    logic       last;
    logic       error;
  } result_t;

  // Everything one byte produces: up to two results sharing an offset
  typedef struct packed {
    logic [1:0]  cnt;
    result_t     res_a;
    result_t     res_b;
    logic [31:0] offset;
  } entry_t;

  // Queue status toward the top level
  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QAW:0]   count;
  } qstat_t;

  // Back-end status toward the top level
  typedef struct packed {
    logic pop;
    logic hold_valid;
    logic out_valid;
  } bstat_t;

  // Outcome of treating a byte as the start of a token
  typedef struct packed {
    logic       emit;
    result_t    res;
    logic [3:0] mode;
  } start_t;

  function automatic result_t mk_res(logic [3:0] kind, logic [7:0] c, logic has,
                                     logic first, logic last, logic err);
    result_t r;
    r.kind      = kind;
    r.text_byte = has ? c : 8'h00;
    r.has_byte  = has;
    r.first     = first;
    r.last      = last;
    r.error     = err;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_name_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_MINUS) || (c == CH_UNDER);
  endfunction

  function automatic logic is_number_char(logic [7:0] c);
    return is_digit(c) || (c == CH_DOT) || (c == CH_LOW_E) || (c == CH_UP_E) ||
           (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic ends_invalid(logic [7:0] c);
    return is_space(c) || (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_EQUALS) ||
           (c == CH_COLON) || (c == CH_COMMA);
  endfunction

  // Byte seen between tokens
  function automatic start_t start_token(logic [7:0] c);
    start_t s;
    s.emit = 1'b1;
    s.mode = M_IDLE;
    s.res  = mk_res(K_EOF, c, 1'b0, 1'b1, 1'b1, 1'b0);
    if (c == CH_NUL) begin
      s.res = mk_res(K_EOF, c, 1'b0, 1'b1, 1'b1, 1'b0);
    end else if (is_space(c)) begin
      s.emit = 1'b0;
    end else if (c == CH_SLASH) begin
      s.emit = 1'b0;
      s.mode = M_SLASH;
    end else if (is_digit(c)) begin
      s.mode = M_NUMBER;
      s.res  = mk_res(K_NUMBER, c, 1'b1, 1'b1, 1'b0, 1'b0);
    end else if (is_alpha(c)) begin
      s.mode = M_NAME;
      s.res  = mk_res(K_NAME, c, 1'b1, 1'b1, 1'b0, 1'b0);
    end else if (c == CH_QUOTE) begin
      s.mode = M_STRING;
      s.res  = mk_res(K_STRING, c, 1'b0, 1'b1, 1'b0, 1'b0);
    end else if (c == CH_LBRACK) begin
      s.mode = M_NODE;
      s.res  = mk_res(K_NODE_BEGIN, c, 1'b0, 1'b1, 1'b0, 1'b0);
    end else begin
      case (c)
        CH_EQUALS: s.res = mk_res(K_EQUALS,    c, 1'b1, 1'b1, 1'b1, 1'b0);
        CH_COLON:  s.res = mk_res(K_COLON,     c, 1'b1, 1'b1, 1'b1, 1'b0);
        CH_COMMA:  s.res = mk_res(K_COMMA,     c, 1'b1, 1'b1, 1'b1, 1'b0);
        CH_BANG:   s.res = mk_res(K_BANG,      c, 1'b1, 1'b1, 1'b1, 1'b0);
        CH_RBRACK: s.res = mk_res(K_NODE_END,  c, 1'b1, 1'b1, 1'b1, 1'b0);
        CH_LBRACE: s.res = mk_res(K_VEC_BEGIN, c, 1'b1, 1'b1, 1'b1, 1'b0);
        CH_RBRACE: s.res = mk_res(K_VEC_END,   c, 1'b1, 1'b1, 1'b1, 1'b0);
        default: begin
          s.mode = M_INVALID;
          s.res  = mk_res(K_INVALID, c, 1'b1, 1'b1, 1'b0, 1'b0);
        end
      endcase
    end
    return s;
  endfunction

endpackage

/* rtl/ttok_front.sv */
// ----------------------------------------------------------------------------
// ttok_front
// Accepts one byte per cycle unless the queue is full, runs the lexer mode
// machine and offset counter, and pushes each byte's results into the queue.
// ----------------------------------------------------------------------------
module ttok_front import ttok_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  logic [3:0]             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [31:0]            offset_clip;
  logic                   accept;
  entry_t                 ent;
  start_t                 st;
  logic [3:0]             cont_kind;
  logic                   cont;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Offset as reported: saturate at 32 bits
  generate
    if (OFFSET_BITS > 32) begin : g_wide
      assign offset_clip = (|offset_r[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF : offset_r[31:0];
    end else if (OFFSET_BITS == 32) begin : g_equal
      assign offset_clip = offset_r;
    end else begin : g_narrow
      assign offset_clip = {{(32-OFFSET_BITS){1'b0}}, offset_r};
    end
  endgenerate

  assign offset_nxt = (offset_r != OFF_MAX) ? offset_r + 1'b1 : offset_r;

  // Mode machine: classify the byte, build up to two results
  always_comb begin
    st         = start_token(in_byte_in);
    mode_nxt   = M_IDLE;
    ent.cnt    = 2'd0;
    ent.res_a  = mk_res(K_EOF, in_byte_in, 1'b0, 1'b1, 1'b1, 1'b0);
    ent.res_b  = mk_res(K_EOF, in_byte_in, 1'b0, 1'b1, 1'b1, 1'b0);
    ent.offset = offset_clip;
    cont_kind  = (mode_r == M_NUMBER) ? K_NUMBER :
                 ((mode_r == M_NAME) ? K_NAME : K_NODE_BEGIN);
    cont       = (mode_r == M_NUMBER) ? is_number_char(in_byte_in)
                                      : is_name_char(in_byte_in);
    case (mode_r)
      M_COMMENT: begin
        if (in_byte_in == CH_NUL) begin
          ent.cnt = 2'd1;
        end else if (in_byte_in != CH_LF) begin
          mode_nxt = M_COMMENT;
        end
      end
      M_SLASH: begin
        if (in_byte_in == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else begin
          ent.res_a = mk_res(K_SLASH_ERROR, in_byte_in, 1'b0, 1'b1, 1'b1, 1'b1);
          ent.cnt   = (in_byte_in == CH_NUL) ? 2'd2 : 2'd1;
        end
      end
      M_NUMBER, M_NAME, M_NODE: begin
        if (cont) begin
          mode_nxt  = mode_r;
          ent.res_a = mk_res(cont_kind, in_byte_in, 1'b1, 1'b0, 1'b0, 1'b0);
          ent.cnt   = 2'd1;
        end else begin
          ent.res_a = mk_res(cont_kind, in_byte_in, 1'b0, 1'b0, 1'b1, 1'b0);
          ent.res_b = st.res;
          ent.cnt   = st.emit ? 2'd2 : 2'd1;
          mode_nxt  = st.mode;
        end
      end
      M_STRING, M_ESCAPE: begin
        if (in_byte_in == CH_NUL) begin
          ent.res_a = mk_res(K_STRING, in_byte_in, 1'b0, 1'b0, 1'b1, 1'b1);
          ent.cnt   = 2'd2;
        end else if (mode_r == M_STRING && in_byte_in == CH_QUOTE) begin
          ent.res_a = mk_res(K_STRING, in_byte_in, 1'b0, 1'b0, 1'b1, 1'b0);
          ent.cnt   = 2'd1;
        end else if (mode_r == M_STRING && in_byte_in == CH_BSLASH) begin
          mode_nxt = M_ESCAPE;
        end else begin
          mode_nxt  = M_STRING;
          ent.res_a = mk_res(K_STRING, in_byte_in, 1'b1, 1'b0, 1'b0, 1'b0);
          ent.cnt   = 2'd1;
        end
      end
      M_INVALID: begin
        if (in_byte_in == CH_NUL) begin
          ent.res_a = mk_res(K_INVALID, in_byte_in, 1'b0, 1'b0, 1'b1, 1'b1);
          ent.cnt   = 2'd2;
        end else if (ends_invalid(in_byte_in)) begin
          ent.res_a = mk_res(K_INVALID, in_byte_in, 1'b0, 1'b0, 1'b1, 1'b0);
          ent.res_b = st.res;
          ent.cnt   = st.emit ? 2'd2 : 2'd1;
          mode_nxt  = st.mode;
        end else begin
          mode_nxt  = M_INVALID;
          ent.res_a = mk_res(K_INVALID, in_byte_in, 1'b1, 1'b0, 1'b0, 1'b0);
          ent.cnt   = 2'd1;
        end
      end
      default: begin
        ent.res_a = st.res;
        ent.cnt   = st.emit ? 2'd1 : 2'd0;
        mode_nxt  = st.mode;
      end
    endcase
  end

  assign push       = accept && (ent.cnt != 2'd0);
  assign push_entry = ent;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      offset_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

/* rtl/ttok_fifo.sv */
// ----------------------------------------------------------------------------
// ttok_fifo
// Short queue of per-byte result groups between front and back.
// ----------------------------------------------------------------------------
module ttok_fifo import ttok_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output qstat_t stat
);

  entry_t         slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign stat.full  = (count_r == QDEPTH[QAW:0]);
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign head    = slot_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* rtl/ttok_back.sv */
// ----------------------------------------------------------------------------
// ttok_back
// Drains queued result groups, one result per cycle when not stalled, into
// the output register. The second result of a group waits in a hold register.
// ----------------------------------------------------------------------------
module ttok_back import ttok_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  entry_t      head,
  input  logic        q_empty,
  output bstat_t      stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_text_byte,
  output logic        out_has_byte,
  output logic        out_first,
  output logic        out_last,
  output logic        out_error,
  output logic [31:0] out_offset
);

  logic        out_valid_r;
  result_t     out_res_r;
  logic [31:0] out_off_r;
  logic        hold_valid_r;
  result_t     hold_res_r;
  logic [31:0] hold_off_r;
  logic        load;
  logic        pop;

  // Output register free or being emptied this cycle
  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !hold_valid_r && !q_empty;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (load) begin
      if (hold_valid_r) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= !q_empty;
        hold_valid_r <= !q_empty && (head.cnt == 2'd2);
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_valid_r) begin
        out_res_r <= hold_res_r;
        out_off_r <= hold_off_r;
      end else if (!q_empty) begin
        out_res_r  <= head.res_a;
        out_off_r  <= head.offset;
        hold_res_r <= head.res_b;
        hold_off_r <= head.offset;
      end
    end
  end

  assign stat.pop        = pop;
  assign stat.hold_valid = hold_valid_r;
  assign stat.out_valid  = out_valid_r;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_res_r.kind;
  assign out_text_byte = out_res_r.text_byte;
  assign out_has_byte  = out_res_r.has_byte;
  assign out_first     = out_res_r.first;
  assign out_last      = out_res_r.last;
  assign out_error     = out_res_r.error;
  assign out_offset    = out_off_r;

endmodule

/* rtl/text_format_tokenizer.sv */
// A byte's first result goes through a queue slot, then the output register.
// Throughput: one byte per cycle while the queue is not full. The output port
// carries one result per cycle while out_stall is low; a byte with two results
// uses it twice, absorbed by a 4-entry queue between lexer front and output stage.
// Reset (synchronous, rst_n low): lexer idle, offset zero, queue and output empty.
// ----------------------------------------------------------------------------
// text_format_tokenizer
// Byte-serial tokenizer for a bracketed key/value text format.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_format_tokenizer import ttok_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_text_byte,
  output logic        out_has_byte,
  output logic        out_first,
  output logic        out_last,
  output logic        out_error,
  output logic [31:0] out_offset
);

  logic   push;
  entry_t push_entry;
  entry_t head;
  qstat_t qstat;
  bstat_t bstat;

  // Front: mode machine and offset counter
  ttok_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte_in (in_byte_in),
    .q_full     (qstat.full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue of result groups
  ttok_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (bstat.pop),
    .head       (head),
    .stat       (qstat)
  );

  // Back: output register and hold slot
  ttok_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (qstat.empty),
    .stat          (bstat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_text_byte (out_text_byte),
    .out_has_byte  (out_has_byte),
    .out_first     (out_first),
    .out_last      (out_last),
    .out_error     (out_error),
    .out_offset    (out_offset)
  );

  // Checks
  `ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, qstat.count <= QDEPTH[QAW:0])
  `ASSERT_IMP(a_hold_needs_out, clk, rst_n, bstat.hold_valid, bstat.out_valid)
  `ASSERT_NEXT(a_pair_held, clk, rst_n, bstat.pop && head.cnt == 2'd2, bstat.hold_valid)
  `ASSERT_IMP(a_no_empty_group, clk, rst_n, push, push_entry.cnt != 2'd0)

endmodule
